// ===== src/w_term_phase_screen_assert.svh =====
`ifndef W_TERM_PHASE_SCREEN_ASSERT_SVH
`define W_TERM_PHASE_SCREEN_ASSERT_SVH
// assertion macros shared by the checker
`define WTPS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: label failed");
`define WTPS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: label failed");
`endif

// ===== src/wtps_pkg.sv =====
package wtps_pkg;
    localparam int unsigned SCREEN_SIZE_DEF   = 1024;
    localparam int unsigned CORDIC_STAGES_DEF = 24;
    localparam int unsigned QUEUE_DEPTH       = 8;
    localparam int unsigned CFG_IDX_W         = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 3'd0,
        CFG_INNER  = 3'd1,
        CFG_STEP_L = 3'd2,
        CFG_STEP_M = 3'd3,
        CFG_W      = 3'd4
    } t_cfg_idx;

    localparam logic signed [34:0] CORDIC_X0 = 35'sd2608131496;

    function automatic logic [31:0] atan_turns(input int unsigned i);
        logic [31:0] t [32];
        t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
              32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
              32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
              32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
              32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
        return t[i[4:0]];
    endfunction

    typedef struct packed {
        logic [47:0] w;
        logic [63:0] rsq;
        logic signed [23:0] pr;
        logic signed [23:0] pi;
        logic               rot;
    } t_work;

    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic               rot;
    } t_res;
endpackage

// ===== src/wtps_if.sv =====
interface wtps_pix_if;
    logic               valid;
    logic               ready;
    logic signed [9:0]  offset_x;
    logic signed [9:0]  offset_y;
    logic signed [23:0] pixel_re;
    logic signed [23:0] pixel_im;
    modport source (output valid, offset_x, offset_y, pixel_re, pixel_im, input ready);
    modport sink   (input valid, offset_x, offset_y, pixel_re, pixel_im, output ready);
endinterface

interface wtps_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] result_re;
    logic signed [23:0] result_im;
    logic               rotated;
    modport source (output valid, result_re, result_im, rotated, input ready);
    modport sink   (input valid, result_re, result_im, rotated, output ready);
endinterface

interface wtps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/wtps_front.sv =====
// classifies pixels and forms l^2+m^2 over three stages
module wtps_front #(
    parameter int unsigned SCREEN_SIZE = wtps_pkg::SCREEN_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [9:0]  i_x,
    input  logic signed [9:0]  i_y,
    input  logic signed [23:0] i_pr,
    input  logic signed [23:0] i_pi,
    input  logic               i_enable,
    input  logic [10:0]        i_inner,
    input  logic [31:0]        i_step_l,
    input  logic [31:0]        i_step_m,
    input  logic [47:0]        i_w,
    output logic               o_valid,
    output wtps_pkg::t_work    o_work
);
    localparam int HS = SCREEN_SIZE / 2;
    logic signed [13:0] half, x, y;
    logic [9:0] ax, ay;
    logic ok0;
    assign half = $signed({4'b0000, i_inner[10:1]});
    assign x = 14'(i_x);
    assign y = 14'(i_y);
    assign ax = i_x[9] ? 10'(-i_x) : i_x;
    assign ay = i_y[9] ? 10'(-i_y) : i_y;
    assign ok0 = i_enable && x >= -half && x < half && y >= -half && y < half
                 && x >= -14'(HS) && x < 14'(HS) && y >= -14'(HS) && y < 14'(HS);

    logic [2:0] r_v;
    logic r_ok1, r_ok2, r_ok3;
    logic [41:0] r_l, r_m;
    logic [63:0] r_lsq, r_msq, r_rsq;
    logic signed [23:0] r_pr [3], r_pi [3];
    logic [47:0] r_w [3];
    logic [64:0] sum;
    assign sum = {1'b0, r_lsq} + {1'b0, r_msq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[1:0], i_valid};
        if (i_en) begin
            r_l <= i_step_l * ax;
            r_m <= i_step_m * ay;
            r_ok1 <= ok0;
            r_ok2 <= r_ok1 && r_l[41:32] == '0 && r_m[41:32] == '0;
            r_lsq <= r_l[31:0] * r_l[31:0];
            r_msq <= r_m[31:0] * r_m[31:0];
            r_ok3 <= r_ok2 && !sum[64];
            r_rsq <= sum[63:0];
            r_pr[0] <= i_pr; r_pr[1] <= r_pr[0]; r_pr[2] <= r_pr[1];
            r_pi[0] <= i_pi; r_pi[1] <= r_pi[0]; r_pi[2] <= r_pi[1];
            r_w[0] <= i_w; r_w[1] <= r_w[0]; r_w[2] <= r_w[1];
        end
    end
    assign o_valid = r_v[2];
    assign o_work = '{w: r_w[2], rsq: r_rsq, pr: r_pr[2], pi: r_pi[2], rot: r_ok3};
endmodule

// ===== src/wtps_queue.sv =====
// short fifo between classifier and rotator
module wtps_queue #(
    parameter int unsigned DEPTH = wtps_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wtps_pkg::t_work i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output wtps_pkg::t_work o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(DEPTH);
    wtps_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
    assign o_valid = r_cnt != '0;
    assign o_data = r_mem[r_rp];
    assign o_count = r_cnt;
endmodule

// ===== src/wtps_back.sv =====
// sqrt (one bit pair per stage), phase, cordic stages, complex multiply
module wtps_back #(
    parameter int unsigned CORDIC_STAGES = wtps_pkg::CORDIC_STAGES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  wtps_pkg::t_work i_work,
    output logic            o_valid,
    output wtps_pkg::t_res  o_res
);
    localparam int SQ = 32;
    // input register, sqrt stages, phase stages, cordic stages, multiply stages
    localparam int LAT = 1 + SQ + 3 + CORDIC_STAGES + 3;
    logic [LAT-1:0] r_v;
    always_ff @(posedge i_clk)
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[LAT-2:0], i_valid};

    function automatic logic signed [23:0] sat(input logic signed [59:0] v);
        if (v > 60'sd8388607) return 24'sd8388607;
        if (v < -60'sd8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    // integer sqrt pipeline
    logic [63:0] r_s [SQ+1], r_rt [SQ+1];
    logic        r_z [SQ+1], r_rot [SQ+1];
    logic [47:0] r_w [SQ+1];
    logic signed [23:0] r_pr [SQ+1], r_pi [SQ+1];
    always_ff @(posedge i_clk) if (i_en) begin
        r_s[0] <= 64'(0) - i_work.rsq; r_rt[0] <= '0; r_z[0] <= i_work.rsq == '0;
        r_rot[0] <= i_work.rot; r_w[0] <= i_work.w;
        r_pr[0] <= i_work.pr; r_pi[0] <= i_work.pi;
    end
    for (genvar k = 0; k < SQ; k++) begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        always_ff @(posedge i_clk) if (i_en) begin
            if (r_s[k] >= r_rt[k] + BIT) begin
                r_s[k+1] <= r_s[k] - (r_rt[k] + BIT);
                r_rt[k+1] <= (r_rt[k] >> 1) + BIT;
            end else begin
                r_s[k+1] <= r_s[k];
                r_rt[k+1] <= r_rt[k] >> 1;
            end
            r_z[k+1] <= r_z[k]; r_rot[k+1] <= r_rot[k]; r_w[k+1] <= r_w[k];
            r_pr[k+1] <= r_pr[k]; r_pi[k+1] <= r_pi[k];
        end
    end

    // phase: w*d, low 48 bits, split multiply over two stages
    logic [32:0] d;
    logic signed [33:0] ds;
    assign d = r_z[SQ] ? 33'd0 : {1'b0, r_rt[SQ][31:0]} - 33'h1_0000_0000;
    assign ds = 34'(signed'(d));
    logic signed [57:0] r_pl;
    logic signed [57:0] r_ph;
    logic r_rot1, r_rot2, r_rot3, r_neg;
    logic signed [23:0] r_pr1, r_pi1, r_pr2, r_pi2, r_pr3, r_pi3;
    logic [47:0] frac;
    logic [31:0] r_p;
    logic signed [32:0] a;
    logic signed [33:0] r_a;
    always_ff @(posedge i_clk) if (i_en) begin
        r_pl <= $signed({1'b0, r_w[SQ][23:0]}) * ds;
        r_ph <= $signed(r_w[SQ][47:24]) * ds;
        r_rot1 <= r_rot[SQ]; r_pr1 <= r_pr[SQ]; r_pi1 <= r_pi[SQ];
    end
    assign frac = 48'(r_pl) + {r_ph[23:0], 24'd0};
    always_ff @(posedge i_clk) if (i_en) begin
        r_rot2 <= r_rot1; r_pr2 <= r_pr1; r_pi2 <= r_pi1;
        r_p <= 32'((frac + 48'h8000) >> 16);
    end
    assign a = $signed({r_p[31], r_p});
    always_ff @(posedge i_clk) if (i_en) begin
        r_rot3 <= r_rot2; r_pr3 <= r_pr2; r_pi3 <= r_pi2;
        if (a > 33'sd1073741824) begin
            r_a <= 34'(a) - 34'sd2147483648; r_neg <= 1'b1;
        end else if (a < -33'sd1073741824) begin
            r_a <= 34'(a) + 34'sd2147483648; r_neg <= 1'b1;
        end else begin
            r_a <= 34'(a); r_neg <= 1'b0;
        end
    end

    // cordic stages
    localparam int N = CORDIC_STAGES;
    logic signed [34:0] r_cx [N+1], r_cy [N+1];
    logic signed [33:0] r_cz [N+1];
    logic r_cn [N+1], r_cr [N+1];
    logic signed [23:0] r_cpr [N+1], r_cpi [N+1];
    always_comb begin
        r_cx[0] = wtps_pkg::CORDIC_X0; r_cy[0] = '0; r_cz[0] = r_a;
        r_cn[0] = r_neg; r_cr[0] = r_rot3; r_cpr[0] = r_pr3; r_cpi[0] = r_pi3;
    end
    for (genvar k = 0; k < N; k++) begin : g_cor
        localparam logic signed [33:0] AT = $signed({2'b00, wtps_pkg::atan_turns(k)});
        always_ff @(posedge i_clk) if (i_en) begin
            if (!r_cz[k][33]) begin
                r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                r_cz[k+1] <= r_cz[k] - AT;
            end else begin
                r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                r_cz[k+1] <= r_cz[k] + AT;
            end
            r_cn[k+1] <= r_cn[k]; r_cr[k+1] <= r_cr[k];
            r_cpr[k+1] <= r_cpr[k]; r_cpi[k+1] <= r_cpi[k];
        end
    end

    // complex multiply, round and saturate
    logic signed [34:0] cx, cy;
    assign cx = r_cn[N] ? -r_cx[N] : r_cx[N];
    assign cy = r_cn[N] ? -r_cy[N] : r_cy[N];
    logic signed [58:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [59:0] r_sre, r_sim;
    logic r_mr, r_mr2, r_mr3;
    logic signed [23:0] r_opr, r_opi, r_opr2, r_opi2, r_ore, r_oim;
    logic r_orot;
    always_ff @(posedge i_clk) if (i_en) begin
        r_m0 <= r_cpr[N] * cx; r_m1 <= r_cpi[N] * cy;
        r_m2 <= r_cpr[N] * cy; r_m3 <= r_cpi[N] * cx;
        r_mr <= r_cr[N]; r_opr <= r_cpr[N]; r_opi <= r_cpi[N];
        r_sre <= 60'(r_m0) - 60'(r_m1) + 60'sd2147483648;
        r_sim <= 60'(r_m2) + 60'(r_m3) + 60'sd2147483648;
        r_mr2 <= r_mr; r_opr2 <= r_opr; r_opi2 <= r_opi;
        r_orot <= r_mr2;
        r_ore <= r_mr2 ? sat(r_sre >>> 32) : r_opr2;
        r_oim <= r_mr2 ? sat(r_sim >>> 32) : r_opi2;
    end
    assign o_valid = r_v[LAT-1];
    assign o_res = '{re: r_ore, im: r_oim, rot: r_orot};
endmodule

// ===== src/w_term_phase_screen.sv =====
// W-term phase screen: every pixel request yields one result; enabled pixels inside the
// window and horizon are rotated by exp(i*2*pi*w*(sqrt(1-l^2-m^2)-1)). One pixel per cycle
// sustained when the queue has room; the path runs through the classify stages, the queue, an input
// register, 32 square-root stages, 3 phase stages, CORDIC_STAGES rotation stages and 3
// multiply stages; only the back pipe stalls, from the result side, and the queue absorbs
// the front's in-flight items.
module w_term_phase_screen #(
    parameter int unsigned SCREEN_SIZE   = wtps_pkg::SCREEN_SIZE_DEF,
    parameter int unsigned CORDIC_STAGES = wtps_pkg::CORDIC_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wtps_pix_if.sink   pix,
    wtps_res_if.source res,
    wtps_cfg_if.sink   cfg
);
    localparam int unsigned QD = wtps_pkg::QUEUE_DEPTH;
    logic r_enable;
    logic [10:0] r_inner;
    logic [31:0] r_step_l, r_step_m;
    logic [47:0] r_w;
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0; r_inner <= '0; r_step_l <= '0; r_step_m <= '0; r_w <= '0;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                wtps_pkg::CFG_ENABLE: r_enable <= cfg.data[0];
                wtps_pkg::CFG_INNER:  r_inner <= cfg.data[10:0];
                wtps_pkg::CFG_STEP_L: r_step_l <= cfg.data[31:0];
                wtps_pkg::CFG_STEP_M: r_step_m <= cfg.data[31:0];
                wtps_pkg::CFG_W:      r_w <= cfg.data;
                default: ;
            endcase
        end
    end

    // back pipe advances when its output slot is free or taken
    logic back_en, f_v, q_v, q_pop, b_v;
    logic [$clog2(QD+1)-1:0] q_cnt;
    wtps_pkg::t_work f_w, q_w;
    wtps_pkg::t_res b_r;
    assign back_en = !b_v || res.ready;
    assign q_pop = q_v && back_en;
    // front stops taking requests while the queue could not hold its in-flight items
    assign pix.ready = q_cnt <= ($clog2(QD+1))'(QD - 4);

    wtps_front #(.SCREEN_SIZE(SCREEN_SIZE)) u_front (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_valid(pix.valid && pix.ready),
        .i_x(pix.offset_x), .i_y(pix.offset_y), .i_pr(pix.pixel_re), .i_pi(pix.pixel_im),
        .i_enable(r_enable), .i_inner(r_inner), .i_step_l(r_step_l), .i_step_m(r_step_m),
        .i_w(r_w), .o_valid(f_v), .o_work(f_w));
    wtps_queue #(.DEPTH(QD)) u_queue (
        .i_clk, .i_rst_n, .i_push(f_v), .i_data(f_w), .i_pop(q_pop),
        .o_valid(q_v), .o_data(q_w), .o_count(q_cnt));
    wtps_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk, .i_rst_n, .i_en(back_en), .i_valid(q_pop), .i_work(q_w),
        .o_valid(b_v), .o_res(b_r));
    assign res.valid = b_v;
    assign res.result_re = b_r.re;
    assign res.result_im = b_r.im;
    assign res.rotated = b_r.rot;
endmodule

// ===== src/wtps_checker.sv =====
`include "w_term_phase_screen_assert.svh"
module wtps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic pr, rv, rr, rrot,
    input logic [23:0] rre
);
    `WTPS_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, rv && !rr, rv && $stable(rre))
    `WTPS_ASSERT_NXT(a_rot_hold, i_clk, i_rst_n, rv && !rr, $stable(rrot))
    `WTPS_ASSERT_IMP(a_no_x_ready, i_clk, i_rst_n, 1'b1, !$isunknown(pr))
endmodule

bind w_term_phase_screen wtps_checker u_chk (
    .i_clk, .i_rst_n, .pr(pix.ready), .rv(res.valid), .rr(res.ready),
    .rrot(res.rotated), .rre(res.result_re));

// ===== sim/w_term_phase_screen_tb.sv =====
`timescale 1ns / 1ps

module w_term_phase_screen_tb;
    localparam int          N_PHASES  = 10;
    localparam int          PER_PHASE = 112;
    localparam int          LAT       = 80;
    localparam int          LIMIT     = 400000;
    localparam logic [2:0]  CFG_NONE  = 3'd7;
    localparam longint      GAIN_X0   = 64'sd2608131496;
    localparam longint      HALF_Q32  = 64'sd2147483648;
    localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;

    typedef struct {
        logic signed [9:0]  x;
        logic signed [9:0]  y;
        logic signed [23:0] re;
        logic signed [23:0] im;
        bit                 typed;
        logic signed [23:0] ere;
        logic signed [23:0] eim;
        bit                 erot;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wtps_pix_if pix_bus ();
    wtps_res_if res_bus ();
    wtps_cfg_if cfg_bus ();

    w_term_phase_screen dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .pix    (pix_bus),
        .res    (res_bus),
        .cfg    (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    // screen settings as the block should hold them
    bit          m_en;
    logic [10:0] m_inner;
    logic [31:0] m_l;
    logic [31:0] m_m;
    logic [47:0] m_w;

    longint arc_turns [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    wtps_pkg::t_res pending_pixels [$];
    int     errors = 0;
    int     cyc = 0;
    bit     calm = 0;
    bit     hold_req = 0;
    t_row   tab_off [0:3];
    t_row   tab_on [0:9];

    function automatic logic [23:0] sat_round(input longint v);
        longint s;
        s = (v + HALF_Q32) >>> 32;
        if (s > 8388607) return 24'sd8388607;
        if (s < -8388608) return -24'sd8388608;
        return s[23:0];
    endfunction

    function automatic wtps_pkg::t_res screen_pixel(input logic signed [9:0] x,
                                                    input logic signed [9:0] y,
                                                    input logic signed [23:0] pr,
                                                    input logic signed [23:0] pim);
        wtps_pkg::t_res r;
        longint      half, ax, ay, a, cx, cy, z, dx, dy;
        logic [63:0] vl, vm, lsq, msq, rsq, root, rem, bitv, d, wx, frac, p;
        bit          ok, neg;
        r.re = pr;
        r.im = pim;
        r.rot = 1'b0;
        half = longint'(m_inner >> 1);
        ok = m_en && x >= -half && x < half && y >= -half && y < half;
        ax = (x < 0) ? -longint'(x) : longint'(x);
        ay = (y < 0) ? -longint'(y) : longint'(y);
        vl = {32'b0, m_l} * 64'(ax);
        vm = {32'b0, m_m} * 64'(ay);
        ok = ok && vl < ONE_Q32 && vm < ONE_Q32;
        lsq = vl * vl;
        msq = vm * vm;
        ok = ok && lsq <= ~msq;
        if (!ok) return r;
        rsq = lsq + msq;
        if (rsq == 0) begin
            root = ONE_Q32;
        end else begin
            rem = 64'd0 - rsq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        d = root - ONE_Q32;
        wx = {{16{m_w[47]}}, m_w};
        frac = (wx * d) & 64'hFFFF_FFFF_FFFF;
        p = ((frac + 64'd32768) >> 16) & 64'hFFFF_FFFF;
        a = (p >= 64'h8000_0000) ? longint'(p) - longint'(ONE_Q32) : longint'(p);
        // fold into a quarter turn either side, flipping the sign of the result
        neg = 1'b0;
        if (a > 64'sd1073741824) begin
            a = a - HALF_Q32;
            neg = 1'b1;
        end else if (a < -64'sd1073741824) begin
            a = a + HALF_Q32;
            neg = 1'b1;
        end
        cx = GAIN_X0;
        cy = 0;
        z = a;
        for (int i = 0; i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                z = z - arc_turns[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                z = z + arc_turns[i];
            end
        end
        if (neg) begin
            cx = -cx;
            cy = -cy;
        end
        r.re = sat_round(longint'(pr) * cx - longint'(pim) * cy);
        r.im = sat_round(longint'(pr) * cy + longint'(pim) * cx);
        r.rot = 1'b1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cyc);
        errors++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            wtps_pkg::CFG_ENABLE: m_en = val[0];
            wtps_pkg::CFG_INNER:  m_inner = val[10:0];
            wtps_pkg::CFG_STEP_L: m_l = val[31:0];
            wtps_pkg::CFG_STEP_M: m_m = val[31:0];
            wtps_pkg::CFG_W:      m_w = val;
            default: ;
        endcase
    endtask

    task automatic setup(input bit en, input logic [10:0] inner, input logic [31:0] sl,
                         input logic [31:0] sm, input logic [47:0] w);
        write_reg(wtps_pkg::CFG_ENABLE, {47'b0, en});
        write_reg(wtps_pkg::CFG_INNER, {37'b0, inner});
        write_reg(wtps_pkg::CFG_STEP_L, {16'b0, sl});
        write_reg(wtps_pkg::CFG_STEP_M, {16'b0, sm});
        write_reg(wtps_pkg::CFG_W, w);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it when a gap follows
    task automatic send_pixel(input t_row row);
        wtps_pkg::t_res e;
        pix_bus.valid <= 1'b1;
        pix_bus.offset_x <= row.x;
        pix_bus.offset_y <= row.y;
        pix_bus.pixel_re <= row.re;
        pix_bus.pixel_im <= row.im;
        do @(posedge i_clk); while (!pix_bus.ready);
        if (row.typed) begin
            e.re = row.ere;
            e.im = row.eim;
            e.rot = row.erot;
        end else begin
            e = screen_pixel(row.x, row.y, row.re, row.im);
        end
        pending_pixels.push_back(e);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_step(input int half);
        longint top;
        int     r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'hFFFF_FFFF;
        if (r == 1) return $urandom();
        top = (longint'(ONE_Q32) * 6) / (5 * ((half > 0) ? half : 512));
        if (top > 64'sd4294967295) top = 64'sd4294967295;
        return $urandom_range(0, 32'(top));
    endfunction

    function automatic logic [23:0] rand_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 24'h7FFFFF;
        if (r == 1) return 24'h800000;
        return $urandom();
    endfunction

    function automatic logic [9:0] rand_offset(input int half);
        if (half > 0 && $urandom_range(0, 4) != 0)
            return 10'($urandom_range(0, 2 * half - 1) - half);
        return $urandom();
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            if (hold_req) begin
                res_bus.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                res_bus.ready <= 1'b0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 50)) @(posedge i_clk);
                else repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        wtps_pkg::t_res e;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_pixels.size() == 0) begin
                report("unexpected result", res_bus.result_re, 0);
            end else begin
                e = pending_pixels.pop_front();
                if (res_bus.result_re !== e.re) report("result_re", res_bus.result_re, e.re);
                if (res_bus.result_im !== e.im) report("result_im", res_bus.result_im, e.im);
                if (res_bus.rotated !== e.rot) report("rotated", res_bus.rotated, e.rot);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("FAIL w_term_phase_screen");
            $finish;
        end
    end

    initial begin
        int          half;
        t_row        row;
        logic [47:0] wv;
        pix_bus.valid <= 1'b0;
        pix_bus.offset_x <= '0;
        pix_bus.offset_y <= '0;
        pix_bus.pixel_re <= '0;
        pix_bus.pixel_im <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        m_en = 0; m_inner = 0; m_l = 0; m_m = 0; m_w = 0;

        // after reset everything passes through
        tab_off = '{
            '{10'sd0, 10'sd0, 24'sh7FFFFF, 24'sh800000, 1, 24'sh7FFFFF, 24'sh800000, 0},
            '{-10'sd512, 10'sd511, 24'sh800000, 24'sh7FFFFF, 1, 24'sh800000, 24'sh7FFFFF, 0},
            '{10'sd5, -10'sd3, 24'sd0, 24'sd0, 1, 24'sd0, 24'sd0, 0},
            '{-10'sd1, -10'sd1, 24'sd1, -24'sd1, 1, 24'sd1, -24'sd1, 0}};
        // window of 32, step 1/16: edge of the window, horizon, centre, saturation
        tab_on = '{
            '{10'sd0, 10'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0},
            '{10'sd16, 10'sd0, 24'sd100, 24'sd200, 1, 24'sd100, 24'sd200, 0},
            '{10'sd0, -10'sd17, 24'sd5, -24'sd5, 1, 24'sd5, -24'sd5, 0},
            '{-10'sd16, 10'sd0, 24'sd7, 24'sd9, 1, 24'sd7, 24'sd9, 0},
            '{10'sd12, 10'sd12, -24'sd3, 24'sd4, 1, -24'sd3, 24'sd4, 0},
            '{10'sd15, -10'sd15, 24'sd1000, 24'sd1000, 1, 24'sd1000, 24'sd1000, 0},
            '{10'sd3, 10'sd4, 24'sh800000, 24'sh800000, 0, 0, 0, 0},
            '{-10'sd15, 10'sd15, 24'sh7FFFFF, 24'sh800000, 0, 0, 0, 0},
            '{10'sd8, -10'sd8, 24'sh400000, -24'sh400000, 0, 0, 0, 0},
            '{-10'sd1, 10'sd0, 24'sd1, 24'sd0, 0, 0, 0, 0}};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (tab_off[i]) begin
            send_pixel(tab_off[i]);
            pause(pick_gap());
        end
        pause(1);
        drain();
        write_reg(CFG_NONE, 48'hFFFF_FFFF_FFFF);
        setup(1, 11'd32, 32'h1000_0000, 32'h1000_0000, 48'h0001_2345_8000);
        foreach (tab_on[i]) begin
            send_pixel(tab_on[i]);
            pause(pick_gap());
        end
        pause(1);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            calm = (ph == 4);
            case (ph)
                0: setup(1, 11'd1024, 32'd0, 32'd0, 48'h7FFF_FFFF_FFFF);
                1: setup(1, 11'd1024, 32'hFFFF_FFFF, 32'd1, 48'h8000_0000_0000);
                2: setup(0, 11'd1024, $urandom(), $urandom(), {$urandom(), 16'($urandom())});
                3: setup(1, 11'd0, $urandom(), $urandom(), 48'hFFFF_FFFF_FFFF);
                default: begin
                    half = $urandom_range(0, 9) == 0 ? 1024 : $urandom_range(1, 1023);
                    wv = $urandom_range(0, 2) == 0 ? {$urandom(), 16'($urandom())}
                                                   : 48'(signed'(20'($urandom())));
                    setup($urandom_range(0, 5) != 0, 11'(half), rand_step(half / 2),
                          rand_step(half / 2), wv);
                end
            endcase
            half = int'(m_inner >> 1);
            for (int k = 0; k < PER_PHASE; k++) begin
                if (ph == 5 && k == 40) hold_req = 1;
                if (ph == 6 && k == 50) begin
                    pause(1);
                    while (pending_pixels.size() != 0) @(posedge i_clk);
                end
                row.x = rand_offset(half);
                row.y = rand_offset(half);
                row.re = rand_sample();
                row.im = rand_sample();
                row.typed = 0;
                send_pixel(row);
                pause(pick_gap());
            end
            pause(1);
        end
        calm = 0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS w_term_phase_screen");
        end else begin
            $display("FAIL w_term_phase_screen");
        end
        $finish;
    end
endmodule
